/* rtl/cubic_lateral_curve_eval_defines.svh */
// Assertion macros shared by the curve evaluator RTL.
// Holds no logic; included by files that carry checks.
`ifndef CUBIC_LATERAL_CURVE_EVAL_DEFINES_SVH
`define CUBIC_LATERAL_CURVE_EVAL_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define CLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// implication whose consequent is checked in the next cycle
`define CLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

/* rtl/clc_pkg.sv */
// Package for the cubic curve evaluator: payload types, widths, CORDIC tables.
// No dependencies.
`default_nettype none
package clc_pkg;
    localparam int MaxStages = 32;
    localparam logic signed [63:0] Gain = 64'sd652032874;

    typedef struct packed {
        logic signed [39:0] start_east;
        logic signed [39:0] start_north;
        logic [15:0]        start_heading;
        logic [31:0]        segment_length;
        logic [31:0]        start_offset;
        logic signed [47:0] coef_const;
        logic signed [47:0] coef_linear;
        logic signed [47:0] coef_quad;
        logic signed [47:0] coef_cubic;
        logic [31:0]        station;
    } t_in;

    typedef struct packed {
        logic signed [39:0] point_east;
        logic signed [39:0] point_north;
    } t_out;

    // state handed from cell to cell along the chain
    typedef struct packed {
        logic               vld;
        logic signed [33:0] u;
        logic signed [63:0] acc;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [33:0] r;
        logic [1:0]         q;
        logic signed [47:0] ca;
        logic signed [47:0] cb;
        logic signed [47:0] cc;
        logic signed [39:0] x0;
        logic signed [39:0] y0;
    } t_cell;

    function automatic logic signed [33:0] atan_tab(input int i);
        logic signed [33:0] t;
        case (i)
            0: t = 34'sd536870912;   1: t = 34'sd316933406;
            2: t = 34'sd167458907;   3: t = 34'sd85004756;
            4: t = 34'sd42667331;    5: t = 34'sd21354465;
            6: t = 34'sd10679838;    7: t = 34'sd5340245;
            8: t = 34'sd2670163;     9: t = 34'sd1335087;
            10: t = 34'sd667544;     11: t = 34'sd333772;
            12: t = 34'sd166886;     13: t = 34'sd83443;
            14: t = 34'sd41722;      15: t = 34'sd20861;
            16: t = 34'sd10430;      17: t = 34'sd5215;
            18: t = 34'sd2608;       19: t = 34'sd1304;
            20: t = 34'sd652;        21: t = 34'sd326;
            22: t = 34'sd163;        23: t = 34'sd81;
            24: t = 34'sd41;         25: t = 34'sd20;
            26: t = 34'sd10;         27: t = 34'sd5;
            28: t = 34'sd3;          29: t = 34'sd1;
            30: t = 34'sd1;          default: t = 34'sd0;
        endcase
        return t;
    endfunction

    // saturate a 66-bit value to 64 bits
    function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
        logic signed [63:0] r;
        if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (v < -66'sh0_8000_0000_0000_0000) r = 64'sh8000_0000_0000_0000;
        else r = v[63:0];
        return r;
    endfunction

    // saturate a 128-bit product shifted right to 64 bits
    function automatic logic signed [63:0] satq(input logic signed [127:0] v);
        logic signed [63:0] r;
        if (v > 128'sh7FFF_FFFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (v < -128'sh8000_0000_0000_0000) r = 64'sh8000_0000_0000_0000;
        else r = v[63:0];
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/cubic_lateral_curve_eval.sv */
// One point on a cubic lateral curve per item: the cubic runs by Horner's rule,
// the heading through a chain of CORDIC cells, then rotation and offset.
// One item per cycle; the CORDIC stage count is capped at 32. Each item passes
// the CORDIC cell chain, then the polynomial pipeline and the rotation behind it,
// each multiply being registered. The whole pipe stalls when the output is held
// and full.
// Depends on clc_pkg, clc_cell, clc_mul and the defines header.
`default_nettype none
`include "cubic_lateral_curve_eval_defines.svh"
module cubic_lateral_curve_eval #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire clc_pkg::t_in    i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output clc_pkg::t_out        o_data
);
    import clc_pkg::*;
    localparam int NS = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;

    logic w_en;
    t_cell w_chain [0:NS];
    logic [31:0] w_st;
    logic [31:0] w_z, w_rr;
    logic [1:0]  w_q;

    assign w_en = !o_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_st = (i_data.station > i_data.segment_length) ?
               i_data.segment_length : i_data.station;
        w_z  = {i_data.start_heading, 16'd0};
        w_q  = 2'((w_z + 32'h2000_0000) >> 30);
        w_rr = w_z - {w_q, 30'd0};
        w_chain[0].vld = i_valid;
        w_chain[0].u   = $signed({2'b00, w_st}) - $signed({2'b00, i_data.start_offset});
        w_chain[0].acc = 64'(i_data.coef_cubic);
        w_chain[0].x   = Gain;
        w_chain[0].y   = '0;
        w_chain[0].r   = 34'(signed'(w_rr));
        w_chain[0].q   = w_q;
        w_chain[0].ca  = i_data.coef_const;
        w_chain[0].cb  = i_data.coef_linear;
        w_chain[0].cc  = i_data.coef_quad;
        w_chain[0].x0  = i_data.start_east;
        w_chain[0].y0  = i_data.start_north;
    end

    for (genvar g = 0; g < NS; g++) begin : g_cell
        clc_cell #(.IDX(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_d(w_chain[g]), .o_d(w_chain[g+1])
        );
    end

    // Horner: three steps, each a registered multiply then an add
    t_cell r_h [0:8];
    t_cell n_h [0:8];
    logic signed [63:0] w_prod [0:2];
    logic signed [47:0] w_coef [0:2];
    for (genvar h = 0; h < 3; h++) begin : g_hor
        clc_mul #(.SHIFT(16)) u_mul (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(64'(h == 0 ? w_chain[NS].u : r_h[3*h-1].u)),
            .i_b(h == 0 ? w_chain[NS].acc : r_h[3*h-1].acc),
            .o_p(w_prod[h])
        );
        assign w_coef[h] = (h == 0) ? r_h[3*h+1].cc :
                           (h == 1) ? r_h[3*h+1].cb : r_h[3*h+1].ca;
    end

    always_comb begin
        n_h[0] = w_chain[NS];
        for (int k = 1; k < 9; k++) begin
            n_h[k] = r_h[k-1];
            if (k % 3 == 2)
                n_h[k].acc = sat64(66'(w_coef[k/3]) + 66'(w_prod[k/3]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_h[k].vld <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k < 9; k++) r_h[k] <= n_h[k];
        end
    end

    // rotation: restore quadrant, four products, then sum with saturation
    logic signed [63:0] w_cs, w_sn, w_v, w_ucs, w_usn, w_vsn, w_vcs;
    logic signed [63:0] w_u64;
    always_comb begin
        w_u64 = 64'(r_h[8].u);
        w_v   = r_h[8].acc;
        case (r_h[8].q)
            2'd0: begin w_cs = r_h[8].x;  w_sn = r_h[8].y;  end
            2'd1: begin w_cs = -r_h[8].y; w_sn = r_h[8].x;  end
            2'd2: begin w_cs = -r_h[8].x; w_sn = -r_h[8].y; end
            default: begin w_cs = r_h[8].y; w_sn = -r_h[8].x; end
        endcase
    end
    clc_mul #(.SHIFT(30)) u_ucs (.i_clk(i_clk), .i_en(w_en), .i_a(w_u64), .i_b(w_cs),
                                 .o_p(w_ucs));
    clc_mul #(.SHIFT(30)) u_usn (.i_clk(i_clk), .i_en(w_en), .i_a(w_u64), .i_b(w_sn),
                                 .o_p(w_usn));
    clc_mul #(.SHIFT(46)) u_vsn (.i_clk(i_clk), .i_en(w_en), .i_a(w_v), .i_b(w_sn),
                                 .o_p(w_vsn));
    clc_mul #(.SHIFT(46)) u_vcs (.i_clk(i_clk), .i_en(w_en), .i_a(w_v), .i_b(w_cs),
                                 .o_p(w_vcs));

    logic [1:0] r_rv;
    logic signed [39:0] r_x0 [0:1];
    logic signed [39:0] r_y0 [0:1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (w_en) begin
            r_rv <= {r_rv[0], r_h[8].vld};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0[0] <= r_h[8].x0; r_x0[1] <= r_x0[0];
            r_y0[0] <= r_h[8].y0; r_y0[1] <= r_y0[0];
        end
    end

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        logic signed [39:0] r;
        if (v > 64'sd549755813887) r = 40'sh7F_FFFF_FFFF;
        else if (v < -64'sd549755813888) r = 40'sh80_0000_0000;
        else r = v[39:0];
        return r;
    endfunction

    logic signed [63:0] w_e, w_n;
    always_comb begin
        w_e = sat64(66'(r_x0[1]) + 66'(w_ucs));
        w_e = sat64(66'(w_e) - 66'(w_vsn));
        w_n = sat64(66'(r_y0[1]) + 66'(w_usn));
        w_n = sat64(66'(w_n) + 66'(w_vcs));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_rv[1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_data.point_east  <= sat40(w_e);
            o_data.point_north <= sat40(w_n);
        end
    end

    `CLC_ASSERT_IMP(a_ready_follows_out, i_clk, i_rst_n, !o_valid, o_ready)
    `CLC_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `CLC_ASSERT_NXT(a_tail_moves, i_clk, i_rst_n, w_en && r_rv[1], o_valid)
endmodule
`default_nettype wire

/* rtl/clc_cell.sv */
// One cell of the evaluator chain: one CORDIC micro-rotation per cycle while enabled.
// Depends on clc_pkg.
`default_nettype none
module clc_cell #(
    parameter int IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire clc_pkg::t_cell i_d,
    output clc_pkg::t_cell      o_d
);
    import clc_pkg::*;
    t_cell r_d, n_d;
    logic signed [63:0] w_dx, w_dy;

    always_comb begin
        w_dx = i_d.y >>> IDX;
        w_dy = i_d.x >>> IDX;
        n_d = i_d;
        if (i_d.r >= 0) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.r = i_d.r - atan_tab(IDX);
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.r = i_d.r + atan_tab(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end
    assign o_d = r_d;
endmodule
`default_nettype wire

/* rtl/clc_mul.sv */
// Registered 64x64 signed multiply, split into 32-bit partial products
// over two stages, with floor shift and saturation. Depends on clc_pkg.
`default_nettype none
module clc_mul #(
    parameter int SHIFT = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic signed [63:0]      o_p
);
    import clc_pkg::*;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic        r_neg;
    logic [63:0] w_aa, w_ab;
    logic [127:0] w_mag;
    logic signed [127:0] w_s;

    assign w_aa = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_ab = i_b[63] ? 64'(-i_b) : 64'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= w_aa[31:0] * w_ab[31:0];
            r_p01 <= w_aa[31:0] * w_ab[63:32];
            r_p10 <= w_aa[63:32] * w_ab[31:0];
            r_p11 <= w_aa[63:32] * w_ab[63:32];
            r_neg <= i_a[63] ^ i_b[63];
        end
    end

    always_comb begin
        w_mag = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
              + {r_p11, 64'd0};
        // magnitudes up to 2^126, so one spare sign bit
        w_s = r_neg ? -$signed(w_mag) : $signed(w_mag);
        w_s = w_s >>> SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_p <= satq(w_s);
    end
endmodule
`default_nettype wire

/* dv/cubic_lateral_curve_eval_checker.sv */
// Checker for the cubic curve evaluator: watches both channels, predicts each
// point from the accepted item and compares it in order. Depends on clc_pkg.
module cubic_lateral_curve_eval_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  clc_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  clc_pkg::t_out  i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    import clc_pkg::*;

    localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;

    t_out expected_points[$];
    int   fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_points.size();

    function automatic logic signed [63:0] clip64(input logic signed [129:0] v);
        if (v > 130'(SMax)) return SMax;
        if (v < 130'(SMin)) return SMin;
        return v[63:0];
    endfunction

    // floor(s*t / 2^n), saturated
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] s,
            input logic signed [63:0] t, input int n);
        logic signed [129:0] p;
        p = 130'(s) * 130'(t);
        return clip64(p >>> n);
    endfunction

    function automatic logic signed [63:0] clip_sum(input logic signed [63:0] a,
            input logic signed [63:0] b);
        return clip64(130'(a) + 130'(b));
    endfunction

    function automatic logic signed [63:0] arctan_turns(input int i);
        logic signed [63:0] k [32] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
            326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return k[i];
    endfunction

    function automatic logic signed [39:0] to_field(input logic signed [63:0] v);
        if (v > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
        if (v < -64'sd549755813888) return 40'sh80_0000_0000;
        return v[39:0];
    endfunction

    function automatic t_out predict_point(input t_in d);
        logic [31:0]        z, rr;
        logic [1:0]         quad;
        logic signed [63:0] r, x, y, dx, dy, cs, sn, u, acc, v, e, nn;
        logic [31:0]        st;
        t_out               res;
        z    = {d.start_heading, 16'h0};
        quad = 2'((z + 32'h2000_0000) >> 30);
        rr   = z - {quad, 30'h0};
        r    = 64'(signed'(rr));
        x    = Gain;
        y    = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x -= dx; y += dy; r -= arctan_turns(i);
            end else begin
                x += dx; y -= dy; r += arctan_turns(i);
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        st  = (d.station > d.segment_length) ? d.segment_length : d.station;
        u   = $signed({32'h0, st}) - $signed({32'h0, d.start_offset});
        acc = 64'(d.coef_cubic);
        acc = clip_sum(64'(d.coef_quad), scaled_product(u, acc, 16));
        acc = clip_sum(64'(d.coef_linear), scaled_product(u, acc, 16));
        v   = clip_sum(64'(d.coef_const), scaled_product(u, acc, 16));
        e   = clip_sum(64'(d.start_east), scaled_product(u, cs, 30));
        e   = clip64(130'(e) - 130'(scaled_product(v, sn, 46)));
        nn  = clip_sum(64'(d.start_north), scaled_product(u, sn, 30));
        nn  = clip_sum(nn, scaled_product(v, cs, 46));
        res.point_east  = to_field(e);
        res.point_north = to_field(nn);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_in_valid && i_in_ready)
            expected_points.push_back(predict_point(i_in_data));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected point %h", i_out_data);
            end else begin
                want = expected_points.pop_front();
                if (want.point_east !== i_out_data.point_east ||
                        want.point_north !== i_out_data.point_north) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("point mismatch: east exp %h got %h, north exp %h got %h",
                            want.point_east, i_out_data.point_east,
                            want.point_north, i_out_data.point_north);
                end
            end
        end
    end
endmodule

/* dv/cubic_lateral_curve_eval_tb.sv */
// Top of the curve evaluator bench: clock, reset, stimulus and verdict.
// Depends on clc_pkg, the block and cubic_lateral_curve_eval_checker.
module cubic_lateral_curve_eval_tb;
    import clc_pkg::*;

    localparam int Stages    = 16;
    localparam int NumRandom = 800;
    localparam int IdleLimit = 20000;

    logic  clk = 0;
    logic  rst_n = 0;
    logic  in_valid = 0;
    logic  in_ready;
    t_in   in_data = '0;
    logic  out_valid;
    logic  out_ready = 0;
    t_out  out_data;
    int    fail_count, pending;
    int    idle_cycles = 0;
    bit    stimulus_done = 0;

    always #5 clk = ~clk;

    cubic_lateral_curve_eval #(.CORDIC_STAGES(Stages)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_data(in_data), .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data)
    );

    cubic_lateral_curve_eval_checker #(.CORDIC_STAGES(Stages)) checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_length();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // coefficient of random magnitude, sometimes an extreme
    function automatic logic signed [47:0] rand_coef();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 48'sh7FFF_FFFF_FFFF;
        if (k == 1) return 48'sh8000_0000_0000;
        if (k < 4) return 48'(rand64());
        return 48'(signed'(rand64()) >>> $urandom_range(16, 63));
    endfunction

    function automatic t_in random_item();
        t_in d;
        int  k;
        d.start_east     = ($urandom_range(0, 7) == 0) ? 40'(rand64())
                           : 40'(signed'(rand64()) >>> $urandom_range(24, 60));
        d.start_north    = ($urandom_range(0, 7) == 0) ? 40'(rand64())
                           : 40'(signed'(rand64()) >>> $urandom_range(24, 60));
        d.start_heading  = 16'($urandom());
        d.segment_length = $urandom() >> $urandom_range(0, 12);
        k = $urandom_range(0, 3);
        d.start_offset   = (k == 0) ? $urandom() : (k == 1) ? 32'h0
                           : $urandom_range(0, d.segment_length);
        d.coef_const     = rand_coef();
        d.coef_linear    = rand_coef();
        d.coef_quad      = rand_coef();
        d.coef_cubic     = rand_coef();
        d.station        = ($urandom_range(0, 5) == 0) ? $urandom()
                           : $urandom_range(0, d.segment_length);
        return d;
    endfunction

    // drop valid only for a real gap, so back-to-back items keep it high
    task automatic send_item(input t_in d);
        int n;
        n = gap_length();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin
        t_in d;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // field extremes, clamping, negative u and saturation
        d = '0;
        send_item(d);
        d = '1;
        send_item(d);
        d = '{40'sh7F_FFFF_FFFF, 40'sh80_0000_0000, 16'h2000, 32'hFFFF_FFFF, 32'h0,
              48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
              48'sh7FFF_FFFF_FFFF, 32'hFFFF_FFFF};
        send_item(d);
        d = '{40'sh80_0000_0000, 40'sh7F_FFFF_FFFF, 16'hE000, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
              48'sh8000_0000_0000, 48'sh8000_0000_0000, 32'h0};
        send_item(d);
        for (int h = 0; h < 8; h++) begin
            d = '{40'sd0, 40'sd0, 16'(h * 16'h2000), 32'h0010_0000, 32'h0,
                  48'sh1_0000_0000, 48'sh0_1000_0000, -48'sh0_0100_0000,
                  48'sh0_0001_0000, 32'h0008_0000};
            send_item(d);
        end
        // station past the end is clamped
        d.station = 32'h0100_0000;
        send_item(d);
        // offset above the station: extrapolate behind the start
        d.start_offset = 32'h0050_0000;
        send_item(d);
        d.start_heading = 16'h1FFF;
        send_item(d);
        d.start_heading = 16'h6000;
        send_item(d);
        for (int i = 0; i < NumRandom; i++)
            send_item(random_item());
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 19) < 13) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stimulus_done);
        while (pending != 0 && idle_cycles < IdleLimit)
            @(posedge clk);
        if (idle_cycles < IdleLimit)
            repeat (Stages + 40) @(posedge clk);
        if (idle_cycles >= IdleLimit || fail_count != 0)
            $display("*** FAILED ***");
        else
            $display("*** PASSED ***");
        $finish;
    end

    always @(posedge clk) begin
        if (idle_cycles >= IdleLimit && !stimulus_done) begin
            $display("*** FAILED ***");
            $finish;
        end
    end
endmodule
